[design/mtpd_pkg.sv]
package mtpd_pkg;

   localparam int MAX_DIM_DEF = 16;

   // fixed field widths
   localparam int NODE_W    = 8;
   localparam int NODES_W   = 9;   // node count, up to 16*16
   localparam int NBITS_W   = 4;   // ceil(log2(nodes)), 0..8
   localparam int SEL_W     = 3;   // bit index into a node id
   localparam int CFG_DIM_W = 5;
   localparam int PAT_W     = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_MESH_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN     = 2'd2;

   localparam logic [PAT_W-1:0] PAT_TRANSPOSE1  = 3'd0;
   localparam logic [PAT_W-1:0] PAT_TRANSPOSE2  = 3'd1;
   localparam logic [PAT_W-1:0] PAT_BIT_REVERSE = 3'd2;
   localparam logic [PAT_W-1:0] PAT_SHUFFLE     = 3'd3;
   localparam logic [PAT_W-1:0] PAT_BUTTERFLY   = 3'd4;

   localparam logic [CFG_DIM_W-1:0] DIM_RESET = 5'd4;
   localparam logic [PAT_W-1:0]     PAT_RESET = PAT_TRANSPOSE1;

   // id / X by multiply: q = (id * ceil(2^16 / X)) >> 16, exact for 8-bit ids
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;

   function automatic logic [RECIP_W-1:0] recip_of(input logic [CFG_DIM_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         5'd1:    r = 17'd65536;
         5'd2:    r = 17'd32768;
         5'd3:    r = 17'd21846;
         5'd4:    r = 17'd16384;
         5'd5:    r = 17'd13108;
         5'd6:    r = 17'd10923;
         5'd7:    r = 17'd9363;
         5'd8:    r = 17'd8192;
         5'd9:    r = 17'd7282;
         5'd10:   r = 17'd6554;
         5'd11:   r = 17'd5958;
         5'd12:   r = 17'd5462;
         5'd13:   r = 17'd5042;
         5'd14:   r = 17'd4682;
         5'd15:   r = 17'd4370;
         5'd16:   r = 17'd4096;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [NBITS_W-1:0] ceil_log2(input logic [NODES_W-1:0] n);
      logic [NBITS_W-1:0] k;
      k = NBITS_W'(NODES_W - 1);
      for (int i = NODES_W - 2; i >= 0; i--) begin
         if ((NODES_W'(1) << i) >= n) k = NBITS_W'(i);
      end
      return k;
   endfunction

endpackage

[design/mtpd_split.sv]
// Two stages: clamp dimensions and pick the reciprocal, then the
// reciprocal multiply giving y = id / X, plus node count and bit count.
module mtpd_split #(
   parameter int MAX_DIM = mtpd_pkg::MAX_DIM_DEF,
   localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mtpd_pkg::CFG_DIM_W-1:0] cfg_width,
   input  logic [mtpd_pkg::CFG_DIM_W-1:0] cfg_height,
   input  logic [mtpd_pkg::PAT_W-1:0]     cfg_pattern,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [mtpd_pkg::NODE_W-1:0]    in_src,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [mtpd_pkg::NODE_W-1:0]    out_src,
   output logic [mtpd_pkg::PAT_W-1:0]     out_pat,
   output logic [DIM_W-1:0]               out_xd,
   output logic [DIM_W-1:0]               out_yd,
   output logic [mtpd_pkg::NODE_W-1:0]    out_q,
   output logic [mtpd_pkg::NODES_W-1:0]   out_nodes,
   output logic [mtpd_pkg::NBITS_W-1:0]   out_nbits
);
   import mtpd_pkg::*;

   localparam int PROD_W = NODE_W + RECIP_W;

   typedef struct packed {
      logic [NODE_W-1:0]  src;
      logic [PAT_W-1:0]   pat;
      logic [DIM_W-1:0]   xd;
      logic [DIM_W-1:0]   yd;
      logic [RECIP_W-1:0] recip;
   } s1_type;

   typedef struct packed {
      logic [NODE_W-1:0]  src;
      logic [PAT_W-1:0]   pat;
      logic [DIM_W-1:0]   xd;
      logic [DIM_W-1:0]   yd;
      logic [NODE_W-1:0]  q;
      logic [NODES_W-1:0] nodes;
      logic [NBITS_W-1:0] nbits;
   } s2_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) r = DIM_W'(1);
      else if (int'(d) > MAX_DIM) r = DIM_W'(MAX_DIM);
      else r = DIM_W'(d);
      return r;
   endfunction

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic   s1_valid_ff, s1_valid_in;
   logic   s2_valid_ff, s2_valid_in;
   logic   s1_ready, s2_ready;

   logic [PROD_W-1:0]    prod;
   logic [2*DIM_W-1:0]   area;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1
   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = in_valid;
      end
      if (in_valid && s1_ready) begin
         s1_in.src   = in_src;
         s1_in.pat   = cfg_pattern;
         s1_in.xd    = clamp_dim(cfg_width);
         s1_in.yd    = clamp_dim(cfg_height);
         s1_in.recip = recip_of(CFG_DIM_W'(clamp_dim(cfg_width)));
      end
   end

   // stage 2
   assign prod = PROD_W'(s1_ff.src) * PROD_W'(s1_ff.recip);
   assign area = (2 * DIM_W)'(s1_ff.xd) * (2 * DIM_W)'(s1_ff.yd);

   always_comb begin
      s2_in       = s2_ff;
      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_in.src   = s1_ff.src;
         s2_in.pat   = s1_ff.pat;
         s2_in.xd    = s1_ff.xd;
         s2_in.yd    = s1_ff.yd;
         s2_in.q     = prod[RECIP_SHIFT +: NODE_W];
         s2_in.nodes = NODES_W'(area);
         s2_in.nbits = ceil_log2(NODES_W'(area));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_src   = s2_ff.src;
   assign out_pat   = s2_ff.pat;
   assign out_xd    = s2_ff.xd;
   assign out_yd    = s2_ff.yd;
   assign out_q     = s2_ff.q;
   assign out_nodes = s2_ff.nodes;
   assign out_nbits = s2_ff.nbits;

endmodule

[design/mtpd_route.sv]
// x = id - y*X, then the transposed coordinates and the bit-pattern ids.
module mtpd_route #(
   parameter int MAX_DIM = mtpd_pkg::MAX_DIM_DEF,
   localparam int DIM_W = $clog2(MAX_DIM + 1),
   localparam int COORD_W = $clog2(MAX_DIM)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [mtpd_pkg::NODE_W-1:0]  in_src,
   input  logic [mtpd_pkg::PAT_W-1:0]   in_pat,
   input  logic [DIM_W-1:0]             in_xd,
   input  logic [DIM_W-1:0]             in_yd,
   input  logic [mtpd_pkg::NODE_W-1:0]  in_q,
   input  logic [mtpd_pkg::NODES_W-1:0] in_nodes,
   input  logic [mtpd_pkg::NBITS_W-1:0] in_nbits,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [DIM_W-1:0]             out_xd,
   output logic [mtpd_pkg::NODES_W-1:0] out_nodes,
   output logic [COORD_W-1:0]           out_dx,
   output logic [COORD_W-1:0]           out_dy,
   output logic [mtpd_pkg::NODE_W-1:0]  out_bits,
   output logic                         out_is_tp
);
   import mtpd_pkg::*;

   localparam int QX_W = NODE_W + DIM_W;

   typedef struct packed {
      logic [DIM_W-1:0]   xd;
      logic [NODES_W-1:0] nodes;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [NODE_W-1:0]  bits;
      logic               is_tp;
   } rt_type;

   function automatic logic [NODE_W-1:0] bit_reverse(input logic [NODE_W-1:0] s,
                                                     input logic [NBITS_W-1:0] n);
      logic [NODE_W-1:0] r;
      r = '0;
      for (int i = 0; i < NODE_W; i++) begin
         if (NBITS_W'(i) < n) r[i] = s[SEL_W'(n - NBITS_W'(1) - NBITS_W'(i))];
      end
      return r;
   endfunction

   // rotate left within the low n bits
   function automatic logic [NODE_W-1:0] shuffle(input logic [NODE_W-1:0] s,
                                                 input logic [NBITS_W-1:0] n);
      logic [NODE_W-1:0] r;
      r = '0;
      for (int i = 0; i < NODE_W; i++) begin
         if (NBITS_W'(i) < n) begin
            if (i == 0) r[i] = s[SEL_W'(n - NBITS_W'(1))];
            else r[i] = s[i-1];
         end
      end
      return r;
   endfunction

   // swap top and bottom bit; with one bit the id is kept
   function automatic logic [NODE_W-1:0] butterfly(input logic [NODE_W-1:0] s,
                                                   input logic [NBITS_W-1:0] n);
      logic [NODE_W-1:0] r;
      r = '0;
      for (int i = 0; i < NODE_W; i++) begin
         if (NBITS_W'(i) < n) begin
            if (NBITS_W'(i) == n - NBITS_W'(1)) r[i] = s[0];
            else if (i == 0) r[i] = s[SEL_W'(n - NBITS_W'(1))];
            else r[i] = s[i];
         end
      end
      return r;
   endfunction

   rt_type rt_ff, rt_in;
   logic   rt_valid_ff, rt_valid_in;

   logic [QX_W-1:0]    qx;
   logic [NODE_W-1:0]  rem;
   logic [COORD_W-1:0] sx;
   logic [COORD_W-1:0] qc;
   logic               q_ge_x;
   logic               sx_ge_y;
   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic [NODE_W-1:0]  bits;

   assign qx      = QX_W'(in_q) * QX_W'(in_xd);
   assign rem     = in_src - qx[NODE_W-1:0];
   assign sx      = rem[COORD_W-1:0];
   assign qc      = in_q[COORD_W-1:0];
   assign q_ge_x  = in_q >= NODE_W'(in_xd);
   assign sx_ge_y = DIM_W'(sx) >= in_yd;

   always_comb begin
      if (in_pat == PAT_TRANSPOSE1) begin
         dx = q_ge_x ? '0 : COORD_W'(in_xd - DIM_W'(1) - DIM_W'(qc));
         dy = sx_ge_y ? '0 : COORD_W'(in_yd - DIM_W'(1) - DIM_W'(sx));
      end else begin
         dx = q_ge_x ? COORD_W'(in_xd - DIM_W'(1)) : qc;
         dy = sx_ge_y ? COORD_W'(in_yd - DIM_W'(1)) : sx;
      end
   end

   always_comb begin
      unique case (in_pat)
         PAT_BIT_REVERSE: bits = bit_reverse(in_src, in_nbits);
         PAT_SHUFFLE:     bits = shuffle(in_src, in_nbits);
         PAT_BUTTERFLY:   bits = butterfly(in_src, in_nbits);
         default:         bits = '0;
      endcase
   end

   assign in_ready = !rt_valid_ff || out_ready;

   always_comb begin
      rt_in       = rt_ff;
      rt_valid_in = rt_valid_ff;
      if (in_ready) begin
         rt_valid_in = in_valid;
      end
      if (in_valid && in_ready) begin
         rt_in.xd    = in_xd;
         rt_in.nodes = in_nodes;
         rt_in.dx    = dx;
         rt_in.dy    = dy;
         rt_in.bits  = bits;
         rt_in.is_tp = in_pat inside {PAT_TRANSPOSE1, PAT_TRANSPOSE2};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff <= 1'b0;
      end else begin
         rt_valid_ff <= rt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rt_ff <= rt_in;
   end

   assign out_valid = rt_valid_ff;
   assign out_xd    = rt_ff.xd;
   assign out_nodes = rt_ff.nodes;
   assign out_dx    = rt_ff.dx;
   assign out_dy    = rt_ff.dy;
   assign out_bits  = rt_ff.bits;
   assign out_is_tp = rt_ff.is_tp;

endmodule

[design/mtpd_merge.sv]
// Rebuilds y*X + x for the transposes, picks the result, flags ids past the mesh.
module mtpd_merge #(
   parameter int MAX_DIM = mtpd_pkg::MAX_DIM_DEF,
   localparam int DIM_W = $clog2(MAX_DIM + 1),
   localparam int COORD_W = $clog2(MAX_DIM)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [DIM_W-1:0]             in_xd,
   input  logic [mtpd_pkg::NODES_W-1:0] in_nodes,
   input  logic [COORD_W-1:0]           in_dx,
   input  logic [COORD_W-1:0]           in_dy,
   input  logic [mtpd_pkg::NODE_W-1:0]  in_bits,
   input  logic                         in_is_tp,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [mtpd_pkg::NODE_W-1:0]  out_dest,
   output logic                         out_beyond
);
   import mtpd_pkg::*;

   localparam int ID_W = COORD_W + DIM_W + 1;

   typedef struct packed {
      logic [NODE_W-1:0] dest;
      logic              beyond;
   } res_type;

   res_type res_ff, res_in;
   logic    res_valid_ff, res_valid_in;

   logic [ID_W-1:0]   tp_id;
   logic [NODE_W-1:0] dest;

   assign tp_id = ID_W'(in_dy) * ID_W'(in_xd) + ID_W'(in_dx);

   always_comb begin
      if (in_nodes <= NODES_W'(1)) dest = '0;
      else if (in_is_tp) dest = NODE_W'(tp_id);
      else dest = in_bits;
   end

   assign in_ready = !res_valid_ff || out_ready;

   always_comb begin
      res_in       = res_ff;
      res_valid_in = res_valid_ff;
      if (in_ready) begin
         res_valid_in = in_valid;
      end
      if (in_valid && in_ready) begin
         res_in.dest   = dest;
         res_in.beyond = NODES_W'(dest) >= in_nodes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_valid  = res_valid_ff;
   assign out_dest   = res_ff.dest;
   assign out_beyond = res_ff.beyond;

endmodule

[design/mesh_traffic_pattern_destination_core.sv]
// Synthetic traffic destination unit for an X by Y mesh.
// req_*: one source node id per item. rsp_*: the destination id picked by the
// configured pattern (transpose1, transpose2, bit reversal, shuffle,
// butterfly) and a flag for an id at or past X*Y.
// csr_*: write-only registers mesh width, mesh height and pattern; write them
// only while no item is in flight. Dimensions saturate into 1..MAX_DIM.
// Four register stages: dimension clamp and reciprocal pick, reciprocal
// multiply for id / X, coordinate and bit-pattern mapping, then the y*X + x
// rebuild into the output register. One item per cycle is sustained while
// rsp_tready stays high.
// Each stage holds its item when the next one is full and stalled, so a stalled rsp
// backs up stage by stage; req_tready drops only once every stage is full.
// Reset: mesh 4 by 4, pattern transpose1, pipeline empty.
module mesh_traffic_pattern_destination_core #(
   parameter int MAX_DIM = mtpd_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] source_node
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [7:0] dest_node
   output logic [0:0]                      rsp_tuser,  // [0] beyond_mesh
   input  logic                            csr_we,
   input  logic [mtpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mtpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mtpd_pkg::*;

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int COORD_W = $clog2(MAX_DIM);

   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [PAT_W-1:0]     pattern_ff, pattern_in;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      pattern_in = pattern_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MESH_WIDTH:  width_in   = csr_wdata;
            CSR_MESH_HEIGHT: height_in  = csr_wdata;
            CSR_PATTERN:     pattern_in = csr_wdata[PAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_RESET;
         height_ff  <= DIM_RESET;
         pattern_ff <= PAT_RESET;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         pattern_ff <= pattern_in;
      end
   end

   logic               split_valid, split_ready;
   logic [NODE_W-1:0]  split_src, split_q;
   logic [PAT_W-1:0]   split_pat;
   logic [DIM_W-1:0]   split_xd, split_yd;
   logic [NODES_W-1:0] split_nodes;
   logic [NBITS_W-1:0] split_nbits;

   logic               route_valid, route_ready;
   logic [DIM_W-1:0]   route_xd;
   logic [NODES_W-1:0] route_nodes;
   logic [COORD_W-1:0] route_dx, route_dy;
   logic [NODE_W-1:0]  route_bits;
   logic               route_is_tp;

   mtpd_split #(.MAX_DIM(MAX_DIM)) u_split (
      .clock       (clock),
      .reset       (reset),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .cfg_pattern (pattern_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_src      (req_tdata),
      .out_valid   (split_valid),
      .out_ready   (split_ready),
      .out_src     (split_src),
      .out_pat     (split_pat),
      .out_xd      (split_xd),
      .out_yd      (split_yd),
      .out_q       (split_q),
      .out_nodes   (split_nodes),
      .out_nbits   (split_nbits)
   );

   mtpd_route #(.MAX_DIM(MAX_DIM)) u_route (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_src    (split_src),
      .in_pat    (split_pat),
      .in_xd     (split_xd),
      .in_yd     (split_yd),
      .in_q      (split_q),
      .in_nodes  (split_nodes),
      .in_nbits  (split_nbits),
      .out_valid (route_valid),
      .out_ready (route_ready),
      .out_xd    (route_xd),
      .out_nodes (route_nodes),
      .out_dx    (route_dx),
      .out_dy    (route_dy),
      .out_bits  (route_bits),
      .out_is_tp (route_is_tp)
   );

   mtpd_merge #(.MAX_DIM(MAX_DIM)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (route_valid),
      .in_ready   (route_ready),
      .in_xd      (route_xd),
      .in_nodes   (route_nodes),
      .in_dx      (route_dx),
      .in_dy      (route_dy),
      .in_bits    (route_bits),
      .in_is_tp   (route_is_tp),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_dest   (rsp_tdata),
      .out_beyond (rsp_tuser[0])
   );

   // backpressure at the input can only come from a full, stalled output
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled output");

   a_route_load: assert property (@(posedge clock) disable iff (reset)
      split_valid && split_ready |=> route_valid)
      else $error("item lost between split and route stages");

   a_route_hold: assert property (@(posedge clock) disable iff (reset)
      route_valid && !route_ready |=> route_valid && $stable(route_dx)
         && $stable(route_dy) && $stable(route_bits))
      else $error("route stage changed while stalled");

   // an id past the mesh is at least the node count, so never zero
   a_beyond_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata != '0)
      else $error("beyond_mesh set on node zero");

endmodule

[bench/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mtpd_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 10;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int BATCH_ITEMS  = 40;

   // pattern codes the block does not define; they must map to node 0
   localparam logic [PAT_W-1:0] PAT_RSVD5 = 3'd5;
   localparam logic [PAT_W-1:0] PAT_RSVD6 = 3'd6;
   localparam logic [PAT_W-1:0] PAT_RSVD7 = 3'd7;

   typedef struct packed {
      logic [NODE_W-1:0] dest_node;
      logic              beyond_mesh;
   } route_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MESH_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the block's registers
   logic [CFG_DIM_W-1:0]  mesh_w_cfg = DIM_RESET;
   logic [CFG_DIM_W-1:0]  mesh_h_cfg = DIM_RESET;
   logic [PAT_W-1:0]      pattern_cfg = PAT_RESET;

   route_type route_q[$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 16;
   int        recv_idle_pct = 50;
   int        hold_requests = 0;
   int        hold_seen = 0;
   int        hold_left = 0;

   mesh_traffic_pattern_destination_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] d);
      if (d < 1) return 1;
      if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(d);
   endfunction

   function automatic route_type predict_route(input logic [7:0] src);
      int          xd, yd, nodes, nbits, sx, sy, dx, dy;
      logic [31:0] dest;
      route_type   r;
      xd = clamp_dim(mesh_w_cfg);
      yd = clamp_dim(mesh_h_cfg);
      nodes = xd * yd;
      nbits = 0;
      while (nbits < 16 && (1 << nbits) < nodes) nbits++;
      sx = int'(src) % xd;
      sy = int'(src) / xd;
      dest = '0;
      if (nodes > 1) begin
         case (pattern_cfg)
            PAT_TRANSPOSE1, PAT_TRANSPOSE2: begin
               if (pattern_cfg == PAT_TRANSPOSE1) begin
                  dx = xd - 1 - sy;
                  dy = yd - 1 - sx;
               end else begin
                  dx = sy;
                  dy = sx;
               end
               if (dx < 0) dx = 0;
               if (dy < 0) dy = 0;
               if (dx >= xd) dx = xd - 1;
               if (dy >= yd) dy = yd - 1;
               dest = 32'(dy * xd + dx);
            end
            PAT_BIT_REVERSE: begin
               for (int i = 0; i < nbits; i++) dest[i] = src[nbits - 1 - i];
            end
            PAT_SHUFFLE: begin
               for (int i = 0; i + 1 < nbits; i++) dest[i + 1] = src[i];
               dest[0] = src[nbits - 1];
            end
            PAT_BUTTERFLY: begin
               for (int i = 1; i + 1 < nbits; i++) dest[i] = src[i];
               dest[0] = src[nbits - 1];
               dest[nbits - 1] = src[0];
            end
            default: dest = '0;
         endcase
      end
      r.dest_node   = dest[7:0];
      r.beyond_mesh = (int'(dest[7:0]) >= nodes);
      return r;
   endfunction

   // predict at the edge that takes the item
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) route_q = {route_q, predict_route(req_tdata)};
   end

   always @(posedge clock) begin
      route_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (route_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item: dest_node %0d beyond_mesh %0d",
                     $time, rsp_tdata, rsp_tuser[0]);
         end else begin
            want = route_q.pop_front();
            if (rsp_tdata !== want.dest_node) begin
               error_count++;
               $display("%0t: dest_node mismatch: expected %0d, actual %0d",
                        $time, want.dest_node, rsp_tdata);
            end
            if (rsp_tuser[0] !== want.beyond_mesh) begin
               error_count++;
               $display("%0t: beyond_mesh mismatch: expected %0d, actual %0d",
                        $time, want.beyond_mesh, rsp_tuser[0]);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_source(input logic [7:0] src);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= src;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (route_q.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MESH_WIDTH:  mesh_w_cfg = value;
         CSR_MESH_HEIGHT: mesh_h_cfg = value;
         CSR_PATTERN:     pattern_cfg = value[PAT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_mesh(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                           input logic [PAT_W-1:0] pat);
      wait_idle();
      csr_write(CSR_MESH_WIDTH, w);
      csr_write(CSR_MESH_HEIGHT, h);
      csr_write(CSR_PATTERN, CSR_DATA_W'(pat));
   endtask

   task automatic directed_item(input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h,
                                input logic [PAT_W-1:0] pat, input logic [7:0] src);
      if (w != mesh_w_cfg || h != mesh_h_cfg || pat != pattern_cfg) set_mesh(w, h, pat);
      send_source(src);
   endtask

   function automatic logic [CFG_DIM_W-1:0] random_dim();
      int r;
      r = $urandom_range(99);
      if (r < 8) return CFG_DIM_W'($urandom_range(31));
      if (r < 16) return CFG_DIM_W'(1);
      if (r < 24) return CFG_DIM_W'(MAX_DIM_DEF);
      return CFG_DIM_W'($urandom_range(MAX_DIM_DEF, 1));
   endfunction

   function automatic logic [PAT_W-1:0] random_pattern();
      if ($urandom_range(99) < 10) return PAT_W'($urandom_range(PAT_RSVD7, PAT_RSVD5));
      return PAT_W'($urandom_range(PAT_BUTTERFLY, PAT_TRANSPOSE1));
   endfunction

   // mostly ids inside the mesh, the rest anywhere in the 8-bit range
   function automatic logic [7:0] random_source();
      int nodes;
      nodes = clamp_dim(mesh_w_cfg) * clamp_dim(mesh_h_cfg);
      if ($urandom_range(99) < 70) return 8'($urandom_range(nodes - 1));
      return 8'($urandom_range(255));
   endfunction

   task automatic test_reset_defaults();
      send_source(8'd0);
      send_source(8'd5);
      send_source(8'd15);
      send_source(8'd255);
   endtask

   task automatic test_directed_cases();
      directed_item(5'd4, 5'd4, PAT_TRANSPOSE2, 8'd6);
      directed_item(5'd3, 5'd5, PAT_TRANSPOSE1, 8'd14);
      directed_item(5'd3, 5'd5, PAT_TRANSPOSE2, 8'd255);
      directed_item(5'd16, 5'd16, PAT_BIT_REVERSE, 8'd1);
      directed_item(5'd16, 5'd16, PAT_BIT_REVERSE, 8'd255);
      directed_item(5'd3, 5'd5, PAT_BIT_REVERSE, 8'd15);   // lands past the mesh
      directed_item(5'd3, 5'd5, PAT_BIT_REVERSE, 8'd240);  // high bits ignored
      directed_item(5'd16, 5'd16, PAT_SHUFFLE, 8'd128);
      directed_item(5'd16, 5'd16, PAT_SHUFFLE, 8'd127);
      directed_item(5'd5, 5'd3, PAT_SHUFFLE, 8'd255);
      directed_item(5'd16, 5'd16, PAT_BUTTERFLY, 8'h81);
      directed_item(5'd16, 5'd16, PAT_BUTTERFLY, 8'h7e);
      directed_item(5'd2, 5'd1, PAT_BUTTERFLY, 8'd1);      // one address bit
      directed_item(5'd1, 5'd1, PAT_TRANSPOSE1, 8'd200);   // single node
      directed_item(5'd1, 5'd1, PAT_BIT_REVERSE, 8'd255);
      directed_item(5'd0, 5'd0, PAT_SHUFFLE, 8'd77);       // zero dims read as one
      directed_item(5'd31, 5'd31, PAT_TRANSPOSE2, 8'd255); // saturate to max
      directed_item(5'd0, 5'd16, PAT_TRANSPOSE1, 8'd9);
      directed_item(5'd16, 5'd16, PAT_RSVD5, 8'd33);
      directed_item(5'd16, 5'd16, PAT_RSVD6, 8'd255);
      directed_item(5'd16, 5'd16, PAT_RSVD7, 8'd0);
      directed_item(5'd16, 5'd1, PAT_TRANSPOSE1, 8'd255);
      directed_item(5'd1, 5'd16, PAT_TRANSPOSE2, 8'd255);
   endtask

   task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int b = 0; b < items / BATCH_ITEMS; b++) begin
         set_mesh(random_dim(), random_dim(), random_pattern());
         for (int n = 0; n < BATCH_ITEMS; n++) send_source(random_source());
      end
   endtask

   // receiver holds off while the sender keeps offering, so the pipe fills
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_mesh(5'd16, 5'd16, PAT_SHUFFLE);
      hold_requests++;
      for (int n = 0; n < 60; n++) send_source(8'($urandom_range(255)));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_random_traffic(260, 16, 50);
      test_random_traffic(260, 50, 16);
      test_backpressure();
      test_random_traffic(280, 0, 0);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
